// ===== hw/rtl/maf_pkg.sv =====
// package for the moving average filter: queue entry, config group, constants
// and the back-end state type; used by every module of the block
package maf_pkg;

  localparam int MAX_LENGTH_DEFAULT = 64;

  localparam int SAMPLE_W     = 16;
  localparam int FILT_LEN_W   = 7;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_LENGTH = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_VALUE = CFG_INDEX_W'(1);

  localparam logic [FILT_LEN_W-1:0] FILTER_LENGTH_RESET = FILT_LEN_W'(64);
  localparam logic [SAMPLE_W-1:0]   INITIAL_VALUE_RESET = '0;

  // queue depth must be a power of two so the pointers wrap by themselves
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                refill;
  } entry_t;

  typedef struct packed {
    logic [FILT_LEN_W-1:0] filter_length;
    logic [SAMPLE_W-1:0]   initial_value;
    logic                  refill;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic pop;
  } back_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOAD,
    B_SUM,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

// ===== hw/rtl/moving_average_filter.sv =====
// boxcar moving average: one average per sample, floor of window sum / length
// the back end works on one item at a time, held by its bit-serial divider;
// the queue takes new items while the back end works
// reset: synchronous, length 64, initial value 0, window all zero, no sweep
// a write to the length or initial value register refills the window at once through per-slot valid bits
module moving_average_filter #(
  parameter int MAX_LENGTH = maf_pkg::MAX_LENGTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [maf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [maf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [maf_pkg::SAMPLE_W-1:0]     sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [maf_pkg::SAMPLE_W-1:0]     average
);

  maf_pkg::entry_t             q_entry;
  maf_pkg::entry_t             q_head;
  maf_pkg::cfg_t               cfg;
  maf_pkg::back_status_t       back_status;
  logic                        q_push;
  logic                        q_full;
  logic                        q_valid;
  logic [maf_pkg::QCNT_W-1:0]  q_count;

  maf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry),
    .cfg       (cfg)
  );

  maf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (back_status.pop),
    .head_valid (q_valid),
    .head       (q_head),
    .full       (q_full),
    .count      (q_count)
  );

  maf_back #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .status    (back_status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .average   (average)
  );

`ifndef NO_ASSERTIONS
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    back_status.pop |-> (q_count != '0))
    else $error("back end popped an empty queue");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> (q_count < maf_pkg::QCNT_W'(maf_pkg::QUEUE_DEPTH)))
    else $error("item accepted into a full queue");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    back_status.pop |=> !back_status.idle)
    else $error("back end did not start on a popped item");
`endif

endmodule

// ===== hw/rtl/maf_front.sv =====
// front end: configuration registers, input handshake and refill tagging
// depends on maf_pkg
module maf_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [maf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [maf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [maf_pkg::SAMPLE_W-1:0]     sample,
  input  logic                             q_full,
  output logic                             q_push,
  output maf_pkg::entry_t                  q_entry,
  output maf_pkg::cfg_t                    cfg
);

  logic [maf_pkg::FILT_LEN_W-1:0] filter_length;
  logic [maf_pkg::SAMPLE_W-1:0]   initial_value;
  logic                           refill_pending;
  logic                           cfg_hit;

  assign cfg_hit = cfg_write && ((cfg_index == maf_pkg::REG_FILTER_LENGTH) ||
                                 (cfg_index == maf_pkg::REG_INITIAL_VALUE));

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_length  <= maf_pkg::FILTER_LENGTH_RESET;
      initial_value  <= maf_pkg::INITIAL_VALUE_RESET;
      refill_pending <= 1'b0;
    end else begin
      if (cfg_write && (cfg_index == maf_pkg::REG_FILTER_LENGTH)) begin
        filter_length <= cfg_data[maf_pkg::FILT_LEN_W-1:0];
      end
      if (cfg_write && (cfg_index == maf_pkg::REG_INITIAL_VALUE)) begin
        initial_value <= cfg_data[maf_pkg::SAMPLE_W-1:0];
      end
      // first item after a refill tells the back end to reload the sum
      if (cfg_hit) begin
        refill_pending <= 1'b1;
      end else if (q_push) begin
        refill_pending <= 1'b0;
      end
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_entry.sample    = sample;
    q_entry.refill    = refill_pending;
    cfg.filter_length = filter_length;
    cfg.initial_value = initial_value;
    cfg.refill        = cfg_hit;
  end

endmodule

// ===== hw/rtl/maf_queue.sv =====
// short item queue between front and back end
// depends on maf_pkg
module maf_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  maf_pkg::entry_t             push_entry,
  input  logic                        pop,
  output logic                        head_valid,
  output maf_pkg::entry_t             head,
  output logic                        full,
  output logic [maf_pkg::QCNT_W-1:0]  count
);

  maf_pkg::entry_t             slots [maf_pkg::QUEUE_DEPTH];
  logic [maf_pkg::QPTR_W-1:0]  rd_ptr;
  logic [maf_pkg::QPTR_W-1:0]  wr_ptr;
  logic                        do_push;
  logic                        do_pop;

  assign head_valid = (count != '0);
  assign full       = (count == maf_pkg::QCNT_W'(maf_pkg::QUEUE_DEPTH));
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== hw/rtl/maf_back.sv =====
// back end: window store, running sum, bit-serial divider and output register
// depends on maf_pkg
module maf_back #(
  parameter int MAX_LENGTH = maf_pkg::MAX_LENGTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  maf_pkg::cfg_t                  cfg,
  input  logic                           q_valid,
  input  maf_pkg::entry_t                q_head,
  output maf_pkg::back_status_t          status,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [maf_pkg::SAMPLE_W-1:0]   average
);

  localparam int LEN_W = $clog2(MAX_LENGTH + 1);
  localparam int POS_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int SUM_W = maf_pkg::SAMPLE_W + $clog2(MAX_LENGTH);
  localparam int CNT_W = $clog2(SUM_W + 1);

  maf_pkg::back_state_t state;
  maf_pkg::back_state_t state_next;

  logic [maf_pkg::SAMPLE_W-1:0] window [MAX_LENGTH];
  logic [MAX_LENGTH-1:0]        slot_valid;
  logic [maf_pkg::SAMPLE_W-1:0] rd_data;
  logic                         rd_valid;

  logic [POS_W-1:0]             write_position;
  logic [POS_W-1:0]             pos_next;
  logic [LEN_W-1:0]             pos_inc;
  logic [LEN_W-1:0]             eff_len;
  logic [maf_pkg::SAMPLE_W-1:0] cur_sample;
  logic                         cur_refill;
  logic [SUM_W-1:0]             window_sum;
  logic [SUM_W-1:0]             sum_upd;
  logic [maf_pkg::SAMPLE_W-1:0] old_value;

  logic [SUM_W-1:0]             quo;
  logic [LEN_W-1:0]             rem;
  logic [LEN_W:0]               rem_shift;
  logic [LEN_W-1:0]             rem_step;
  logic                         quo_bit;
  logic [CNT_W-1:0]             cnt;

  logic                         do_pop;
  logic                         do_write;
  logic                         do_result;
  logic                         out_free;

  always_comb begin
    if (cfg.filter_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (int'(cfg.filter_length) > MAX_LENGTH) begin
      eff_len = LEN_W'(MAX_LENGTH);
    end else begin
      eff_len = LEN_W'(cfg.filter_length);
    end
  end

  // advance first, wrap to zero at the window length
  assign pos_inc  = LEN_W'(write_position) + LEN_W'(1);
  assign pos_next = (pos_inc >= eff_len) ? '0 : POS_W'(pos_inc);

  // slots not written since the last refill hold the initial value
  assign old_value = rd_valid ? rd_data : cfg.initial_value;
  assign sum_upd   = window_sum - SUM_W'(old_value) + SUM_W'(cur_sample);

  // restoring division step, one quotient bit a cycle
  always_comb begin
    rem_shift = {rem, quo[SUM_W-1]};
    if (rem_shift >= {1'b0, eff_len}) begin
      rem_step = LEN_W'(rem_shift - {1'b0, eff_len});
      quo_bit  = 1'b1;
    end else begin
      rem_step = rem_shift[LEN_W-1:0];
      quo_bit  = 1'b0;
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      maf_pkg::B_IDLE: begin
        if (q_valid) state_next = maf_pkg::B_LOAD;
      end
      maf_pkg::B_LOAD: state_next = maf_pkg::B_SUM;
      maf_pkg::B_SUM:  state_next = maf_pkg::B_DIV;
      maf_pkg::B_DIV: begin
        if (cnt == CNT_W'(1)) state_next = maf_pkg::B_DONE;
      end
      maf_pkg::B_DONE: begin
        if (out_free) state_next = maf_pkg::B_IDLE;
      end
      default: state_next = maf_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    do_pop    = 1'b0;
    do_write  = 1'b0;
    do_result = 1'b0;
    case (state)
      maf_pkg::B_IDLE: do_pop    = q_valid;
      maf_pkg::B_SUM:  do_write  = 1'b1;
      maf_pkg::B_DONE: do_result = out_free;
      default: begin
        do_pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    status.idle = (state == maf_pkg::B_IDLE);
    status.pop  = do_pop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= maf_pkg::B_IDLE;
      write_position <= '0;
      window_sum     <= '0;
      slot_valid     <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.refill) begin
        write_position <= '0;
        slot_valid     <= '0;
      end else begin
        if (do_pop) begin
          write_position <= pos_next;
        end
        if (do_write) begin
          slot_valid[write_position] <= 1'b1;
        end
      end
      if (state == maf_pkg::B_LOAD && cur_refill) begin
        window_sum <= SUM_W'(eff_len) * SUM_W'(cfg.initial_value);
      end else if (do_write) begin
        window_sum <= sum_upd;
      end
      if (do_result) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      cur_sample <= q_head.sample;
      cur_refill <= q_head.refill;
    end
    if (state == maf_pkg::B_LOAD) begin
      rd_valid <= slot_valid[write_position];
    end
    if (do_write) begin
      quo <= sum_upd;
      rem <= '0;
      cnt <= CNT_W'(SUM_W);
    end else if (state == maf_pkg::B_DIV) begin
      quo <= {quo[SUM_W-2:0], quo_bit};
      rem <= rem_step;
      cnt <= cnt - CNT_W'(1);
    end
    if (do_result) begin
      average <= quo[maf_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == maf_pkg::B_LOAD) begin
      rd_data <= window[write_position];
    end
    if (do_write) begin
      window[write_position] <= cur_sample;
    end
  end

endmodule

// ===== bench/tb.sv =====
// testbench for moving_average_filter: directed table, then random phases of samples
// under several window settings; each average is checked against its typed value
// or a running-sum predictor; depends on maf_pkg and moving_average_filter (rtl)
`timescale 1ns / 100ps

module tb;

  localparam int WIN_MAX     = maf_pkg::MAX_LENGTH_DEFAULT;
  localparam int HOLD_AT     = 500;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 100;
  localparam int DIR_ROWS    = 29;

  // register indexes with no register behind them
  localparam logic [maf_pkg::CFG_INDEX_W-1:0] REG_UNUSED_2 = maf_pkg::CFG_INDEX_W'(2);
  localparam logic [maf_pkg::CFG_INDEX_W-1:0] REG_UNUSED_3 = maf_pkg::CFG_INDEX_W'(3);

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [maf_pkg::CFG_INDEX_W-1:0]  index;
    logic [maf_pkg::CFG_DATA_W-1:0]   value;
    logic                             has_avg;
    logic [maf_pkg::SAMPLE_W-1:0]     avg;
  } row_t;

  // averages are typed in only where they are plain to see
  localparam row_t DIRECTED [0:DIR_ROWS-1] = '{
    '{ROW_SAMPLE, '0,                         16'hFFFF, 1'b1, 16'd1023},
    '{ROW_SAMPLE, '0,                         16'hFFFF, 1'b1, 16'd2047},
    '{ROW_SAMPLE, '0,                         16'h0000, 1'b0, 16'd0},
    '{ROW_WRITE,  maf_pkg::REG_FILTER_LENGTH, 16'h0001, 1'b0, 16'd0},
    '{ROW_SAMPLE, '0,                         16'hFFFF, 1'b1, 16'hFFFF},
    '{ROW_SAMPLE, '0,                         16'h0000, 1'b1, 16'h0000},
    '{ROW_SAMPLE, '0,                         16'h5A5A, 1'b1, 16'h5A5A},
    '{ROW_SAMPLE, '0,                         16'hA5A5, 1'b1, 16'hA5A5},
    '{ROW_WRITE,  maf_pkg::REG_INITIAL_VALUE, 16'hFFFF, 1'b0, 16'd0},
    '{ROW_WRITE,  maf_pkg::REG_FILTER_LENGTH, 16'hFF40, 1'b0, 16'd0},
    '{ROW_SAMPLE, '0,                         16'hFFFF, 1'b1, 16'hFFFF},
    '{ROW_SAMPLE, '0,                         16'h0000, 1'b1, 16'd64511},
    '{ROW_WRITE,  REG_UNUSED_2,               16'h0001, 1'b0, 16'd0},
    '{ROW_SAMPLE, '0,                         16'h0000, 1'b0, 16'd0},
    '{ROW_WRITE,  REG_UNUSED_3,               16'h0000, 1'b0, 16'd0},
    '{ROW_SAMPLE, '0,                         16'hFFFF, 1'b0, 16'd0},
    '{ROW_WRITE,  maf_pkg::REG_FILTER_LENGTH, 16'h007F, 1'b0, 16'd0},
    '{ROW_SAMPLE, '0,                         16'h0000, 1'b0, 16'd0},
    '{ROW_WRITE,  maf_pkg::REG_INITIAL_VALUE, 16'h8001, 1'b0, 16'd0},
    '{ROW_SAMPLE, '0,                         16'h7FFE, 1'b0, 16'd0},
    '{ROW_WRITE,  maf_pkg::REG_FILTER_LENGTH, 16'h0002, 1'b0, 16'd0},
    '{ROW_SAMPLE, '0,                         16'h0003, 1'b0, 16'd0},
    '{ROW_SAMPLE, '0,                         16'h0005, 1'b0, 16'd0},
    '{ROW_SAMPLE, '0,                         16'h0007, 1'b0, 16'd0},
    '{ROW_WRITE,  maf_pkg::REG_FILTER_LENGTH, 16'h003F, 1'b0, 16'd0},
    '{ROW_SAMPLE, '0,                         16'hFFFF, 1'b0, 16'd0},
    '{ROW_SAMPLE, '0,                         16'h0000, 1'b0, 16'd0},
    '{ROW_WRITE,  maf_pkg::REG_INITIAL_VALUE, 16'h0000, 1'b0, 16'd0},
    '{ROW_SAMPLE, '0,                         16'h0001, 1'b0, 16'd0}
  };

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            cfg_write = 1'b0;
  logic [maf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [maf_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  logic [maf_pkg::SAMPLE_W-1:0]    sample    = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [maf_pkg::SAMPLE_W-1:0]    average;

  moving_average_filter u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .average   (average)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // window predictor
  logic [maf_pkg::FILT_LEN_W-1:0] cur_length;
  logic [maf_pkg::SAMPLE_W-1:0]   cur_init;
  logic [maf_pkg::SAMPLE_W-1:0]   window [WIN_MAX];
  int unsigned                    wr_slot;
  int unsigned                    window_total;

  logic [maf_pkg::SAMPLE_W-1:0]   pending_avgs [$];
  logic [maf_pkg::SAMPLE_W-1:0]   avg_want;
  int                             mismatches    = 0;
  int                             samples_taken = 0;
  bit                             gaps_on       = 1'b1;
  bit                             held_off      = 1'b0;

  function automatic int unsigned window_len();
    if (cur_length == 0) return 1;
    if (cur_length > WIN_MAX) return WIN_MAX;
    return 32'(cur_length);
  endfunction

  function automatic void refill_window();
    for (int i = 0; i < WIN_MAX; i++) window[i] = cur_init;
    wr_slot      = 0;
    window_total = window_len() * 32'(cur_init);
  endfunction

  function automatic void apply_reg(logic [maf_pkg::CFG_INDEX_W-1:0] idx,
                                    logic [maf_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      maf_pkg::REG_FILTER_LENGTH: cur_length = data[maf_pkg::FILT_LEN_W-1:0];
      maf_pkg::REG_INITIAL_VALUE: cur_init = data[maf_pkg::SAMPLE_W-1:0];
      default: return;
    endcase
    refill_window();
  endfunction

  function automatic logic [maf_pkg::SAMPLE_W-1:0] predict_average(
    logic [maf_pkg::SAMPLE_W-1:0] s);
    int unsigned len;
    len = window_len();
    wr_slot = wr_slot + 1;
    if (wr_slot >= len) wr_slot = 0;
    window_total = window_total - 32'(window[wr_slot]) + 32'(s);
    window[wr_slot] = s;
    return maf_pkg::SAMPLE_W'(window_total / len);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer_sample(input logic [maf_pkg::SAMPLE_W-1:0] s, input logic has_avg,
                              input logic [maf_pkg::SAMPLE_W-1:0] avg);
    logic [maf_pkg::SAMPLE_W-1:0] predicted;
    while (gaps_on && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (in_stall);
    predicted = predict_average(s);
    pending_avgs.push_back(has_avg ? avg : predicted);
    samples_taken++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_avgs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [maf_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [maf_pkg::CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    apply_reg(idx, data);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    forever begin
      @(negedge clk);
      if (!held_off && samples_taken >= HOLD_AT) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= gaps_on && ($urandom_range(99) < 33);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_avgs.size() == 0) begin
        $error("average: no item pending, got %0d", average);
        mismatches++;
      end else begin
        avg_want = pending_avgs.pop_front();
        if (average !== avg_want) begin
          $error("average: expected %0d, got %0d", avg_want, average);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned                    len_pick;
    logic [maf_pkg::SAMPLE_W-1:0]   init_pick;
    logic [maf_pkg::CFG_DATA_W-1:0] len_word;
    logic [maf_pkg::SAMPLE_W-1:0]   s;
    logic [maf_pkg::SAMPLE_W-1:0]   last_s;

    cur_length   = maf_pkg::FILTER_LENGTH_RESET;
    cur_init     = maf_pkg::INITIAL_VALUE_RESET;
    for (int i = 0; i < WIN_MAX; i++) window[i] = '0;
    wr_slot      = 0;
    window_total = 0;
    last_s       = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(DIRECTED[r].index, DIRECTED[r].value);
      end else begin
        offer_sample(DIRECTED[r].value, DIRECTED[r].has_avg, DIRECTED[r].avg);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: len_pick = WIN_MAX;
        1: len_pick = 1;
        2: len_pick = 2;
        3: len_pick = WIN_MAX - 1;
        4: len_pick = $urandom_range(127, WIN_MAX + 1);
        // zero length behaves as a window of one
        5: len_pick = 0;
        default: len_pick = $urandom_range(WIN_MAX, 1);
      endcase
      case (ph)
        1: init_pick = '1;
        2: init_pick = '0;
        default: init_pick = maf_pkg::SAMPLE_W'($urandom);
      endcase
      // upper bits of the length word are noise the block should drop
      len_word = maf_pkg::CFG_DATA_W'($urandom);
      len_word[maf_pkg::FILT_LEN_W-1:0] = len_pick[maf_pkg::FILT_LEN_W-1:0];
      if (ph % 2 == 0) begin
        write_reg(maf_pkg::REG_FILTER_LENGTH, len_word);
        write_reg(maf_pkg::REG_INITIAL_VALUE, init_pick);
      end else begin
        write_reg(maf_pkg::REG_INITIAL_VALUE, init_pick);
        write_reg(maf_pkg::REG_FILTER_LENGTH, len_word);
      end
      if ($urandom_range(2) == 0)
        write_reg($urandom_range(1) ? REG_UNUSED_2 : REG_UNUSED_3,
                  maf_pkg::CFG_DATA_W'($urandom));
      gaps_on = (ph != 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(9))
          0: s = '0;
          1: s = '1;
          2: s = last_s;
          default: s = maf_pkg::SAMPLE_W'($urandom);
        endcase
        last_s = s;
        offer_sample(s, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_avgs.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (mismatches == 0 && pending_avgs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
